// ----- rtl/core/load_cell_pad_decoder_core_assert.svh -----
// ----------------------------------------------------------------------------
// Load cell pad decoder assertion macros
// Shared property forms for the decoder core; clk and rst_n must be in scope.
// ----------------------------------------------------------------------------
`ifndef LOAD_CELL_PAD_DECODER_CORE_ASSERT_SVH
`define LOAD_CELL_PAD_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define LCPD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LCPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/lcpd_pkg.sv -----
// ----------------------------------------------------------------------------
// Load cell pad decoder package
// Widths, register codes, reset values, shared types and scaling helpers.
// ----------------------------------------------------------------------------
package lcpd_pkg;

  localparam int WEIGHT_WIDTH         = 16;
  localparam int CENTER_FRACTION_BITS = 10;
  localparam int BAND_SCALE_BITS      = 10;

  localparam int SIDE_W   = WEIGHT_WIDTH + 1;
  localparam int TOTAL_W  = WEIGHT_WIDTH + 2;
  localparam int CENTER_W = CENTER_FRACTION_BITS + 1;

  localparam int PRESS_W    = 15;
  localparam int MIN_W      = 16;
  localparam int BAND_W     = 10;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_INDEX_W = 3;

  localparam int CMP_W     = TOTAL_W + MIN_W;
  localparam int TH_CMP_W  = WEIGHT_WIDTH + PRESS_W + 1;
  localparam int DIV_CNT_W = $clog2(CENTER_FRACTION_BITS + 1);
  localparam int LEAN_W    = CENTER_W + BAND_SCALE_BITS + BAND_W + CENTER_FRACTION_BITS + 2;

  localparam int IN_DATA_W    = ((4 * WEIGHT_WIDTH + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 8 + 2 * CENTER_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [CFG_INDEX_W-1:0] REG_PRESS_THRESHOLD   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_THRESHOLD = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_TOTAL_WEIGHT  = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_BAND       = CFG_INDEX_W'(3);
  localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION_LIMIT   = CFG_INDEX_W'(4);

  localparam logic [PRESS_W-1:0] PRESS_RESET   = PRESS_W'(100);
  localparam logic [PRESS_W-1:0] RELEASE_RESET = PRESS_W'(10);
  localparam logic [MIN_W-1:0]   MIN_RESET     = MIN_W'(100);
  localparam logic [BAND_W-1:0]  BAND_RESET    = BAND_W'(205);
  localparam logic [BAND_W-1:0]  LIMIT_RESET   = BAND_W'(307);

  localparam logic signed [CENTER_W-1:0] CENTER_HALF =
    CENTER_W'(2 ** (CENTER_FRACTION_BITS - 1));
  localparam logic signed [CENTER_W-1:0] CENTER_NEG_HALF = -CENTER_HALF;

  typedef struct packed {
    logic                      start;
    logic signed [SIDE_W-1:0]  side;
    logic signed [TOTAL_W-1:0] total;
  } div_req_t;

  typedef struct packed {
    logic                       busy;
    logic                       done;
    logic signed [CENTER_W-1:0] center;
  } div_rsp_t;

  // Center value in 2^-F units brought onto the common compare scale.
  function automatic logic signed [LEAN_W-1:0] scale_center(
    input logic signed [CENTER_W-1:0] c
  );
    logic signed [LEAN_W-1:0] ext;
    ext = LEAN_W'(c);
    return ext <<< BAND_SCALE_BITS;
  endfunction

  // Register value in 1/1024 units brought onto the common compare scale.
  function automatic logic signed [LEAN_W-1:0] scale_reg(
    input logic [BAND_W-1:0] r
  );
    logic signed [LEAN_W-1:0] ext;
    ext = $signed(LEAN_W'(r));
    return ext <<< CENTER_FRACTION_BITS;
  endfunction

endpackage

// ----- rtl/core/lcpd_hyst.sv -----
// ----------------------------------------------------------------------------
// Corner hysteresis
// Holds the pressed flag of each corner and updates it on every sample beat.
// ----------------------------------------------------------------------------
module lcpd_hyst (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                sample_en,
  input  logic [4*lcpd_pkg::WEIGHT_WIDTH-1:0] weights,
  input  logic [lcpd_pkg::PRESS_W-1:0]        press_threshold,
  input  logic [lcpd_pkg::PRESS_W-1:0]        release_threshold,
  output logic [3:0]                          pressed
);

  logic [3:0]                               pressed_r;
  logic [3:0]                               pressed_nxt;
  logic signed [lcpd_pkg::TH_CMP_W-1:0]     w_ext [4];
  logic signed [lcpd_pkg::TH_CMP_W-1:0]     press_ext;
  logic signed [lcpd_pkg::TH_CMP_W-1:0]     release_ext;

  always_comb begin
    press_ext   = $signed(lcpd_pkg::TH_CMP_W'(press_threshold));
    release_ext = $signed(lcpd_pkg::TH_CMP_W'(release_threshold));
    pressed_nxt = pressed_r;
    for (int i = 0; i < 4; i++) begin
      w_ext[i] = lcpd_pkg::TH_CMP_W'($signed(
        weights[i*lcpd_pkg::WEIGHT_WIDTH +: lcpd_pkg::WEIGHT_WIDTH]));
      // Press wins when both thresholds are met at once.
      if (w_ext[i] >= press_ext) begin
        pressed_nxt[i] = 1'b1;
      end else if (w_ext[i] <= release_ext) begin
        pressed_nxt[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r <= '0;
    end else if (sample_en) begin
      pressed_r <= pressed_nxt;
    end
  end

  assign pressed = pressed_r;

endmodule

// ----- rtl/core/lcpd_div.sv -----
// ----------------------------------------------------------------------------
// Center of pressure divider
// Bit-serial restoring divider giving one quotient bit per cycle, with the
// low-total (zero or below minimum), negative-side and full-side cases settled at start.
// ----------------------------------------------------------------------------
module lcpd_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lcpd_pkg::div_req_t            req,
  input  logic [lcpd_pkg::MIN_W-1:0]    min_total_weight,
  output lcpd_pkg::div_rsp_t            rsp
);

  localparam int RW = lcpd_pkg::TOTAL_W - 1;
  localparam int FB = lcpd_pkg::CENTER_FRACTION_BITS;

  logic                                  busy_r, busy_nxt;
  logic                                  done_r, done_nxt;
  logic [lcpd_pkg::DIV_CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [RW-1:0]                         rem_r, rem_nxt;
  logic [RW-1:0]                         tot_r, tot_nxt;
  logic [FB-1:0]                         quo_r, quo_nxt;
  logic signed [lcpd_pkg::CENTER_W-1:0]  center_r, center_nxt;

  logic                                  is_zero, is_neg, is_sat;
  logic [lcpd_pkg::TOTAL_W-1:0]          rem2, diff;
  logic                                  ge;

  always_comb begin
    is_zero = ($signed(lcpd_pkg::CMP_W'(req.total)) <
               $signed(lcpd_pkg::CMP_W'(min_total_weight))) || (req.total == '0);
    is_neg  = req.side[lcpd_pkg::SIDE_W-1];
    is_sat  = $signed(lcpd_pkg::TOTAL_W'(req.side)) >= req.total;

    rem2 = {rem_r, 1'b0};
    diff = rem2 - lcpd_pkg::TOTAL_W'(tot_r);
    ge   = rem2 >= lcpd_pkg::TOTAL_W'(tot_r);

    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    rem_nxt    = rem_r;
    tot_nxt    = tot_r;
    quo_nxt    = quo_r;
    center_nxt = center_r;

    if (busy_r) begin
      rem_nxt = ge ? diff[RW-1:0] : rem2[RW-1:0];
      quo_nxt = {quo_r[FB-2:0], ge};
      cnt_nxt = cnt_r - lcpd_pkg::DIV_CNT_W'(1);
      if (cnt_r == lcpd_pkg::DIV_CNT_W'(1)) begin
        busy_nxt   = 1'b0;
        done_nxt   = 1'b1;
        center_nxt = $signed(lcpd_pkg::CENTER_W'({1'b0, quo_nxt})) - lcpd_pkg::CENTER_HALF;
      end
    end else if (req.start) begin
      if (is_zero) begin
        done_nxt   = 1'b1;
        center_nxt = '0;
      end else if (is_neg) begin
        done_nxt   = 1'b1;
        center_nxt = lcpd_pkg::CENTER_NEG_HALF;
      end else if (is_sat) begin
        done_nxt   = 1'b1;
        center_nxt = lcpd_pkg::CENTER_HALF;
      end else begin
        // Here 0 <= side < total, so every partial remainder stays below total.
        busy_nxt = 1'b1;
        cnt_nxt  = lcpd_pkg::DIV_CNT_W'(FB);
        rem_nxt  = RW'($unsigned(req.side));
        tot_nxt  = req.total[RW-1:0];
        quo_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    tot_r    <= tot_nxt;
    quo_r    <= quo_nxt;
    center_r <= center_nxt;
  end

  assign rsp.busy   = busy_r;
  assign rsp.done   = done_r;
  assign rsp.center = center_r;

endmodule

// ----- rtl/core/load_cell_pad_decoder_core.sv -----
// ----------------------------------------------------------------------------
// Load cell pad decoder core
// One input beat carries four signed corner weights; one output beat follows
// with the four pressed flags, the up/down/right/left lean flags and the
// signed center of pressure on both axes. Registers are written through the
// cfg port; the user is to write them only while the block is idle, which
// the block itself does not enforce.
// The single divider produces one quotient bit per cycle and runs once for x
// and once for y; an axis settled by the zero, negative or full cases needs
// no division. in_tready is high only while no sample is in work, so a new
// beat is accepted only once the last sample's result has been loaded into
// the output register.
// A finished result sits in the output register; a stalled receiver does not
// block the next input beat, but that sample's result waits until the
// register is taken. Reset clears all corner flags, loads the register
// defaults and leaves the output empty.
// ----------------------------------------------------------------------------
module load_cell_pad_decoder_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: weight_top_left, weight_top_right, weight_bottom_left,
  //           weight_bottom_right
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [lcpd_pkg::IN_DATA_W-1:0]       in_tdata,
  // out_tdata: pressed_top_left, pressed_top_right, pressed_bottom_left,
  //            pressed_bottom_right, lean_up, lean_down, lean_right,
  //            lean_left, center_x, center_y, zero fill
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [lcpd_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  logic                                 cfg_wen,
  input  logic [lcpd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [lcpd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_X_GO   = 3'd1;
  localparam logic [2:0] ST_X_WAIT = 3'd2;
  localparam logic [2:0] ST_Y_GO   = 3'd3;
  localparam logic [2:0] ST_Y_WAIT = 3'd4;
  localparam logic [2:0] ST_OUT    = 3'd5;

  localparam int WW = lcpd_pkg::WEIGHT_WIDTH;
  localparam int CW = lcpd_pkg::CENTER_W;

  logic [2:0] state_r, state_nxt;

  logic [lcpd_pkg::PRESS_W-1:0] press_r, release_r;
  logic [lcpd_pkg::MIN_W-1:0]   min_total_r;
  logic [lcpd_pkg::BAND_W-1:0]  band_r, limit_r;

  logic signed [lcpd_pkg::SIDE_W-1:0]  side_x_r, side_y_r;
  logic signed [lcpd_pkg::TOTAL_W-1:0] total_x_r, total_y_r;
  logic signed [lcpd_pkg::SIDE_W-1:0]  w_tl, w_tr, w_bl, w_br;
  logic signed [lcpd_pkg::SIDE_W-1:0]  right_s, left_s, top_s, bottom_s;

  logic signed [CW-1:0] cx_r, cy_r;

  logic                                out_tvalid_r, out_tvalid_nxt;
  logic [lcpd_pkg::OUT_DATA_W-1:0]     out_tdata_r;
  logic                                out_load;

  logic                   in_accept;
  logic [3:0]             pressed;
  lcpd_pkg::div_req_t     div_req;
  lcpd_pkg::div_rsp_t     div_rsp;

  logic signed [lcpd_pkg::LEAN_W-1:0] sx, sy, ax, ay, band_s, lim_s;
  logic lean_up, lean_down, lean_right, lean_left;

  logic signed [CW-1:0] out_center_x;
  logic                 out_lean_up, out_lean_down;

  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_r     <= lcpd_pkg::PRESS_RESET;
      release_r   <= lcpd_pkg::RELEASE_RESET;
      min_total_r <= lcpd_pkg::MIN_RESET;
      band_r      <= lcpd_pkg::BAND_RESET;
      limit_r     <= lcpd_pkg::LIMIT_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        lcpd_pkg::REG_PRESS_THRESHOLD: begin
          press_r <= cfg_wdata[lcpd_pkg::PRESS_W-1:0];
        end
        lcpd_pkg::REG_RELEASE_THRESHOLD: begin
          release_r <= cfg_wdata[lcpd_pkg::PRESS_W-1:0];
        end
        lcpd_pkg::REG_MIN_TOTAL_WEIGHT: begin
          min_total_r <= cfg_wdata[lcpd_pkg::MIN_W-1:0];
        end
        lcpd_pkg::REG_CENTER_BAND: begin
          band_r <= cfg_wdata[lcpd_pkg::BAND_W-1:0];
        end
        lcpd_pkg::REG_DIRECTION_LIMIT: begin
          limit_r <= cfg_wdata[lcpd_pkg::BAND_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  lcpd_hyst u_hyst (
    .clk               (clk),
    .rst_n             (rst_n),
    .sample_en         (in_accept),
    .weights           (in_tdata[4*WW-1:0]),
    .press_threshold   (press_r),
    .release_threshold (release_r),
    .pressed           (pressed)
  );

  // Axis sums, captured on the input beat.
  always_comb begin
    w_tl     = lcpd_pkg::SIDE_W'($signed(in_tdata[0*WW +: WW]));
    w_tr     = lcpd_pkg::SIDE_W'($signed(in_tdata[1*WW +: WW]));
    w_bl     = lcpd_pkg::SIDE_W'($signed(in_tdata[2*WW +: WW]));
    w_br     = lcpd_pkg::SIDE_W'($signed(in_tdata[3*WW +: WW]));
    right_s  = w_tr + w_br;
    left_s   = w_tl + w_bl;
    top_s    = w_tl + w_tr;
    bottom_s = w_bl + w_br;
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      side_x_r  <= right_s;
      side_y_r  <= top_s;
      total_x_r <= lcpd_pkg::TOTAL_W'(right_s) + lcpd_pkg::TOTAL_W'(left_s);
      total_y_r <= lcpd_pkg::TOTAL_W'(top_s) + lcpd_pkg::TOTAL_W'(bottom_s);
    end
    if (state_r == ST_X_WAIT && div_rsp.done) begin
      cx_r <= div_rsp.center;
    end
    if (state_r == ST_Y_WAIT && div_rsp.done) begin
      cy_r <= div_rsp.center;
    end
  end

  always_comb begin
    div_req.start = (state_r == ST_X_GO) || (state_r == ST_Y_GO);
    div_req.side  = (state_r == ST_Y_GO) ? side_y_r : side_x_r;
    div_req.total = (state_r == ST_Y_GO) ? total_y_r : total_x_r;
  end

  lcpd_div u_div (
    .clk              (clk),
    .rst_n            (rst_n),
    .req              (div_req),
    .min_total_weight (min_total_r),
    .rsp              (div_rsp)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_X_GO;
        end
      end
      ST_X_GO: begin
        state_nxt = ST_X_WAIT;
      end
      ST_X_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = ST_Y_GO;
        end
      end
      ST_Y_GO: begin
        state_nxt = ST_Y_WAIT;
      end
      ST_Y_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Lean decode: both sides are brought to one scale so the compare is exact.
  always_comb begin
    sx     = lcpd_pkg::scale_center(cx_r);
    sy     = lcpd_pkg::scale_center(cy_r);
    ax     = sx[lcpd_pkg::LEAN_W-1] ? -sx : sx;
    ay     = sy[lcpd_pkg::LEAN_W-1] ? -sy : sy;
    band_s = lcpd_pkg::scale_reg(band_r);
    lim_s  = lcpd_pkg::scale_reg(limit_r);
    lean_up    = (ax < band_s) && (sy > lim_s);
    lean_down  = (ax < band_s) && (sy < -lim_s);
    lean_right = (ay < band_s) && (sx > lim_s);
    lean_left  = (ay < band_s) && (sx < -lim_s);
  end

  // Output register.
  assign out_load = (state_r == ST_OUT) && (!out_tvalid_r || out_tready);

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= lcpd_pkg::OUT_DATA_W'({cy_r, cx_r, lean_left, lean_right,
                                            lean_down, lean_up, pressed});
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign out_center_x  = $signed(out_tdata_r[8 +: CW]);
  assign out_lean_up   = out_tdata_r[4];
  assign out_lean_down = out_tdata_r[5];

  `include "load_cell_pad_decoder_core_assert.svh"

  `LCPD_ASSERT_NEXT(a_busy_after_accept, in_accept, !in_tready, "input taken while a sample is in work")
  `LCPD_ASSERT_IMPL(a_div_start_idle, div_req.start, !div_rsp.busy, "divider started while busy")
  `LCPD_ASSERT_IMPL(a_center_x_range, out_tvalid_r, (out_center_x <= lcpd_pkg::CENTER_HALF) && (out_center_x >= lcpd_pkg::CENTER_NEG_HALF), "center_x outside half range")
  `LCPD_ASSERT_IMPL(a_lean_excl, out_tvalid_r, !(out_lean_up && out_lean_down), "lean up and down together")

endmodule
